/* rtl/core/dsrc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrc_pkg: shared types and helpers of the dual-slope radial compressor
// Widths of the fixed point fields, the parameter bundle, the sideband
// records of the root and divide pipelines, and one step of the digit
// by digit square root used by both the parameter unit and the datapath.
// ----------------------------------------------------------------------------
package dsrc_pkg;

	// field widths
	localparam int MAGW  = 32;            // Q16.16 magnitudes
	localparam int KW    = 24;            // slope ratio, Q8.16
	localparam int CIW   = 2;             // register index
	localparam int AMW   = 34;            // |a|, Q.16
	localparam int BW    = 40;            // b, signed Q23.16
	localparam int L2W   = 48;            // lam^2, Q32.16
	localparam int PPHW  = 34;            // upper partial product of a*m
	localparam int PRODW = 50;            // rounded |a*m|
	localparam int VW    = 52;            // signed sums around rho
	localparam int RADW  = 66;            // root radicand, Q.32
	localparam int NPAIR = RADW / 2;      // root digits
	localparam int ROOTW = NPAIR;         // root width
	localparam int REMW  = ROOTW + 3;     // root remainder
	localparam int QW    = 18;            // quotient bits (q never exceeds 1.0)
	localparam int DNUMW = MAGW + 17;     // (mag << 16) + s/2
	localparam int DREMW = ROOTW + QW;    // divider remainder
	localparam int DW    = 36;            // signed derivative before saturation
	localparam int NUMW  = 42;            // numerator of a

	localparam logic [KW-1:0] K_ONE = 24'h010000;

	// register indexes
	localparam logic [CIW-1:0] REG_KNEE  = 2'd0;
	localparam logic [CIW-1:0] REG_SLOPE = 2'd1;
	localparam logic [CIW-1:0] REG_SOFT  = 2'd2;

	typedef struct packed {
		logic [REMW-1:0]  rem;
		logic [ROOTW-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [MAGW-1:0]        r0;
		logic [AMW-1:0]         am;
		logic                   a_neg;
		logic signed [BW-1:0]   b;
		logic [L2W-1:0]         lam2;
		logic                   valid;
	} param_t;

	typedef struct packed {
		logic [MAGW-1:0]      mag;
		logic                 neg;
		logic signed [VW-1:0] v0;
	} sq_side_t;

	typedef struct packed {
		logic [MAGW-1:0] comp;
		logic            neg;
	} dv_side_t;

	// one restoring square root digit
	function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
		logic [REMW-1:0] r2;
		logic [REMW-1:0] trial;
		sq_t nx;
		r2 = {cur.rem[REMW-3:0], pair};
		trial = {1'b0, cur.root, 2'b01};
		nx.root = {cur.root[ROOTW-2:0], 1'b0};
		if (r2 >= trial) begin
			nx.rem = r2 - trial;
			nx.root[0] = 1'b1;
		end else begin
			nx.rem = r2;
		end
		return nx;
	endfunction

	// round to nearest from the final remainder
	function automatic logic [ROOTW-1:0] sqrt_round(input sq_t cur);
		logic [ROOTW-1:0] res;
		res = cur.root;
		if (cur.rem > {{(REMW-ROOTW){1'b0}}, cur.root}) begin
			res = cur.root + 1'b1;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/dual_slope_radial_compress.sv */
`default_nettype none
// Throughput: one radius per cycle while busy is low; the root (33 digit stages and
// a rounding stage) and divider (18 stages) are fully pipelined. busy is high only
// while the curve terms are recomputed, after each configuration word and after reset.
// Reset: asynchronous, active low; registers return to r0 = 0, k = 2.0, lambda = 0
// and a recompute runs at once. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// dual_slope_radial_compress: two-slope hyperbolic radius compressor
// rho = b + a*(r - r0) - sqrt((r - r0)^2 + lam2), negated when a < 0, clamped, with its
// derivative (r - r0)/sqrt(...) + a, saturated.
// ----------------------------------------------------------------------------
module dual_slope_radial_compress (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [31:0]              radius,
	output logic                          result_valid,
	output logic [31:0]                   compressed,
	output logic signed [31:0]            derivative,
	output logic                          config_ok,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [dsrc_pkg::CIW-1:0] cfg_index,
	input  wire logic [31:0]              cfg_data
);
	import dsrc_pkg::*;

	localparam int LAT = NPAIR + QW + 7;

	param_t prm;

	logic                   accept;
	logic                   neg_in;
	logic [MAGW-1:0]        mag_in;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [MAGW-1:0]        mag_s1, mag_s2, mag_s3, mag_s4;
	logic                   neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*MAGW-1:0]      d2_s2, pplo_s2;
	logic [PPHW-1:0]        pphi_s2;
	logic [RADW-1:0]        rad_s3, rad_s4;
	logic [PRODW-1:0]       prod_s3;
	logic                   pneg_s3;
	logic signed [VW-1:0]   v0_s4;
	logic [RADW-1:0]        psum;
	logic signed [VW-1:0]   px;
	logic signed [VW-1:0]   bext;

	sq_side_t               sq_side_in, sq_side_out;
	logic                   sq_valid;
	logic [ROOTW-1:0]       sq_root;

	logic signed [VW-1:0]   sx;
	logic signed [VW-1:0]   diff;
	logic [MAGW-1:0]        comp_c;
	logic [DNUMW-1:0]       num_s5;
	logic [ROOTW-1:0]       den_s5;
	dv_side_t               dv_side_s5, dv_side_out;
	logic                   dv_valid;
	logic [QW-1:0]          dv_quo;

	logic signed [DW-1:0]   qx, ax, dsum;
	logic signed [31:0]     dsat;

	dsrc_param u_param (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.prm       (prm)
	);

	assign accept = start && !busy;

	// distance to the knee
	assign neg_in = radius < prm.r0;
	assign mag_in = neg_in ? (prm.r0 - radius) : (radius - prm.r0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= sq_valid;
		end
	end

	// s2: squares and partial products of a*mag
	// s3: radicand and rounded product
	// s4: b +- product
	assign psum = {2'b00, pplo_s2} + {pphi_s2, 32'h0} + RADW'(16'h8000);
	assign px   = signed'({{(VW-PRODW){1'b0}}, prod_s3});
	assign bext = {{(VW-BW){prm.b[BW-1]}}, prm.b};

	always_ff @(posedge clk) begin
		mag_s1  <= mag_in;
		neg_s1  <= neg_in;

		d2_s2   <= mag_s1 * mag_s1;
		pplo_s2 <= mag_s1 * prm.am[31:0];
		pphi_s2 <= PPHW'(mag_s1) * PPHW'(prm.am[AMW-1:32]);
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;

		rad_s3  <= {2'b00, d2_s2} + {2'b00, prm.lam2, 16'h0};
		prod_s3 <= psum[RADW-1:16];
		pneg_s3 <= prm.a_neg ^ neg_s2;
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;

		v0_s4   <= bext + (pneg_s3 ? -px : px);
		rad_s4  <= rad_s3;
		mag_s4  <= mag_s3;
		neg_s4  <= neg_s3;
	end

	assign sq_side_in.mag = mag_s4;
	assign sq_side_in.neg = neg_s4;
	assign sq_side_in.v0  = v0_s4;

	dsrc_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_rad    (rad_s4),
		.in_side   (sq_side_in),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side_out)
	);

	// s5: rho with sign flip and clamp, divider operands
	assign sx   = signed'({{(VW-ROOTW){1'b0}}, sq_root});
	assign diff = prm.a_neg ? (sx - sq_side_out.v0) : (sq_side_out.v0 - sx);
	always_comb begin
		if (diff[VW-1]) begin
			comp_c = '0;
		end else if (|diff[VW-2:MAGW]) begin
			comp_c = '1;
		end else begin
			comp_c = diff[MAGW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		num_s5          <= {1'b0, sq_side_out.mag, 16'h0} + DNUMW'(sq_root[ROOTW-1:1]);
		den_s5          <= sq_root;
		dv_side_s5.comp <= comp_c;
		dv_side_s5.neg  <= sq_side_out.neg;
	end

	dsrc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_num    (num_s5),
		.in_den    (den_s5),
		.in_side   (dv_side_s5),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side_out)
	);

	// derivative: +-q + a, saturated to 32 bits
	assign qx   = signed'({{(DW-QW){1'b0}}, dv_quo});
	assign ax   = signed'({{(DW-AMW){1'b0}}, prm.am});
	assign dsum = (dv_side_out.neg ? -qx : qx) + (prm.a_neg ? -ax : ax);
	always_comb begin
		if (&dsum[DW-1:31] || ~|dsum[DW-1:31]) begin
			dsat = dsum[31:0];
		end else if (dsum[DW-1]) begin
			dsat = 32'sh8000_0000;
		end else begin
			dsat = 32'sh7FFF_FFFF;
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		compressed <= prm.valid ? dv_side_out.comp : '0;
		derivative <= prm.valid ? dsat : '0;
		config_ok  <= prm.valid;
	end

	// fixed latency, nothing dropped
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT result_valid)
		else $error("result missing at fixed latency");

	// invalid slope ratio yields an all-zero word
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !config_ok) |-> (compressed == '0 && derivative == '0))
		else $error("nonzero result with invalid slope ratio");

endmodule
`default_nettype wire

/* rtl/core/dsrc_param.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrc_param: configuration registers and derived curve terms
// Holds r0, k and lambda and recomputes a, lam^2 and b with a sequencer
// that reuses one bit-serial divider and one digit-serial root.
// ----------------------------------------------------------------------------
module dsrc_param (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [dsrc_pkg::CIW-1:0] cfg_index,
	input  wire logic [31:0]             cfg_data,
	output logic                         busy,
	output dsrc_pkg::param_t             prm
);
	import dsrc_pkg::*;

	localparam int CNTW = $clog2(NUMW);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_LAM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PROD = 3'd4;
	localparam logic [2:0] ST_ROOT = 3'd5;
	localparam logic [2:0] ST_RND  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]             state_q;
	logic [CNTW-1:0]        cnt_q;
	logic [MAGW-1:0]        r0_q;
	logic [MAGW-1:0]        lam_q;
	logic [KW-1:0]          k_q;
	logic [2*MAGW-1:0]      lsq_q;
	logic [2*MAGW-1:0]      r0sq_q;
	logic [L2W-1:0]         lam2_q;
	logic [NUMW-1:0]        divn_q;
	logic [KW-1:0]          drem_q;
	logic [KW-1:0]          dden_q;
	logic [AMW-1:0]         am_q;
	logic [RADW-1:0]        rad_q;
	sq_t                    sq_q;
	logic [2*MAGW-1:0]      pplo_q;
	logic [PPHW-1:0]        pphi_q;
	logic [ROOTW-1:0]       root_q;
	logic [PRODW-1:0]       prod_q;
	logic signed [BW-1:0]   b_q;

	logic                   k_valid;
	logic                   a_neg;
	logic [2*MAGW-1:0]      l2_full;
	logic [L2W-1:0]         l2;
	logic [KW:0]            ksum;
	logic [KW-1:0]          den0;
	logic [NUMW-1:0]        num0;
	logic [KW:0]            drem_n;
	logic [KW:0]            drem_sub;
	logic                   dge;
	logic [AMW-1:0]         am_d;
	logic [RADW-1:0]        rad0;
	logic [RADW-1:0]        psum;
	logic signed [VW-1:0]   bx;
	logic signed [VW-1:0]   px;
	logic signed [BW-1:0]   bsat;

	// derived flags of k
	assign k_valid = (k_q != '0) && (k_q != K_ONE);
	assign a_neg   = k_q < K_ONE;

	// lam^2 rounded to Q32.16
	assign l2_full = lsq_q + 64'h8000;
	assign l2      = l2_full[2*MAGW-1:16];

	// numerator and divisor of a, numerator biased by half the divisor
	assign ksum = {1'b0, k_q} + {1'b0, K_ONE};
	assign den0 = (k_q > K_ONE) ? (k_q - K_ONE) : (K_ONE - k_q);
	assign num0 = NUMW'({ksum, 16'h0}) + NUMW'(den0[KW-1:1]);

	// one quotient bit per cycle
	assign drem_n   = {drem_q, divn_q[NUMW-1]};
	assign drem_sub = drem_n - {1'b0, dden_q};
	assign dge      = drem_n >= {1'b0, dden_q};

	assign am_d = k_valid ? divn_q[AMW-1:0] : '0;
	assign rad0 = {2'b00, r0sq_q} + {2'b00, lam2_q, 16'h0};
	assign psum = {2'b00, pplo_q} + {pphi_q, 32'h0} + RADW'(16'h8000);

	// b = root + a*r0, saturated to 40 bits
	assign px = signed'({{(VW-PRODW){1'b0}}, prod_q});
	assign bx = signed'({{(VW-ROOTW){1'b0}}, root_q}) + (a_neg ? -px : px);
	always_comb begin
		if (&bx[VW-1:BW-1] || ~|bx[VW-1:BW-1]) begin
			bsat = bx[BW-1:0];
		end else if (bx[VW-1]) begin
			bsat = {1'b1, {(BW-1){1'b0}}};
		end else begin
			bsat = {1'b0, {(BW-1){1'b1}}};
		end
	end

	// sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			r0_q    <= '0;
			k_q     <= 24'h020000;
			lam_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_KNEE:  r0_q  <= cfg_data;
							REG_SLOPE: k_q   <= cfg_data[KW-1:0];
							REG_SOFT:  lam_q <= cfg_data;
							default: ;
						endcase
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_LAM;
				ST_LAM: begin
					cnt_q   <= CNTW'(NUMW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					cnt_q   <= CNTW'(NPAIR - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: state_q <= ST_FIN;
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				lsq_q  <= lam_q * lam_q;
				r0sq_q <= r0_q * r0_q;
			end
			ST_LAM: begin
				lam2_q <= (l2 == '0) ? L2W'(1) : l2;
				divn_q <= num0;
				drem_q <= '0;
				dden_q <= den0;
			end
			ST_DIV: begin
				divn_q <= {divn_q[NUMW-2:0], dge};
				drem_q <= dge ? drem_sub[KW-1:0] : drem_n[KW-1:0];
			end
			ST_PROD: begin
				am_q   <= am_d;
				pplo_q <= r0_q * am_d[31:0];
				pphi_q <= PPHW'(r0_q) * PPHW'(am_d[AMW-1:32]);
				rad_q  <= rad0;
				sq_q   <= '0;
			end
			ST_ROOT: begin
				sq_q  <= sqrt_step(sq_q, rad_q[RADW-1 -: 2]);
				rad_q <= {rad_q[RADW-3:0], 2'b00};
			end
			ST_RND: begin
				root_q <= sqrt_round(sq_q);
				prod_q <= psum[RADW-1:16];
			end
			ST_FIN: b_q <= k_valid ? bsat : '0;
			default: ;
		endcase
	end

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = state_q == ST_IDLE;

	assign prm.r0    = r0_q;
	assign prm.am    = am_q;
	assign prm.a_neg = a_neg;
	assign prm.b     = b_q;
	assign prm.lam2  = lam2_q;
	assign prm.valid = k_valid;

	// a recompute always ends in idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> !busy)
		else $error("recompute did not return to idle");

	// every accepted write starts a recompute
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> busy)
		else $error("write did not start recompute");

	// softness floor holds whenever items can run
	a_lam2_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (lam2_q != '0))
		else $error("softness below floor");

endmodule
`default_nettype wire

/* rtl/core/dsrc_sqrt_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrc_sqrt_pipe: pipelined rounded square root
// One root digit per stage over a Q.32 radicand, then a rounding stage.
// Sideband words travel alongside the root.
// ----------------------------------------------------------------------------
module dsrc_sqrt_pipe (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [dsrc_pkg::RADW-1:0] in_rad,
	input  dsrc_pkg::sq_side_t            in_side,
	output logic                          out_valid,
	output logic [dsrc_pkg::ROOTW-1:0]    out_root,
	output dsrc_pkg::sq_side_t            out_side
);
	import dsrc_pkg::*;

	logic            vld_s  [NPAIR];
	sq_t             sq_s   [NPAIR];
	logic [RADW-1:0] rad_s  [NPAIR];
	sq_side_t        side_s [NPAIR];

	for (genvar g = 0; g < NPAIR; g++) begin : g_stage
		logic            v_in;
		sq_t             sq_in;
		logic [RADW-1:0] rad_in;
		sq_side_t        side_in;

		if (g == 0) begin : g_first
			assign v_in    = in_valid;
			assign sq_in   = '0;
			assign rad_in  = in_rad;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[g-1];
			assign sq_in   = sq_s[g-1];
			assign rad_in  = rad_s[g-1];
			assign side_in = side_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= v_in;
			end
		end

		// one digit, radicand shifts up by a pair
		always_ff @(posedge clk) begin
			sq_s[g]   <= sqrt_step(sq_in, rad_in[RADW-1 -: 2]);
			rad_s[g]  <= {rad_in[RADW-3:0], 2'b00};
			side_s[g] <= side_in;
		end
	end

	// rounding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[NPAIR-1];
		end
	end

	always_ff @(posedge clk) begin
		out_root <= sqrt_round(sq_s[NPAIR-1]);
		out_side <= side_s[NPAIR-1];
	end

endmodule
`default_nettype wire

/* rtl/core/dsrc_div_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrc_div_pipe: pipelined restoring divider
// One quotient bit per stage, most significant first. The quotient is
// known to stay below 2^QW for the operands this block feeds it.
// ----------------------------------------------------------------------------
module dsrc_div_pipe (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [dsrc_pkg::DNUMW-1:0] in_num,
	input  wire logic [dsrc_pkg::ROOTW-1:0] in_den,
	input  dsrc_pkg::dv_side_t             in_side,
	output logic                           out_valid,
	output logic [dsrc_pkg::QW-1:0]        out_quo,
	output dsrc_pkg::dv_side_t             out_side
);
	import dsrc_pkg::*;

	logic             vld_s  [QW];
	logic [DREMW-1:0] rem_s  [QW];
	logic [ROOTW-1:0] den_s  [QW];
	logic [QW-1:0]    quo_s  [QW];
	dv_side_t         side_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int J = QW - 1 - g;
		logic             v_in;
		logic [DREMW-1:0] rem_in;
		logic [ROOTW-1:0] den_in;
		logic [QW-1:0]    quo_in;
		dv_side_t         side_in;
		logic [DREMW-1:0] trial;
		logic             ge;

		if (g == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = DREMW'(in_num);
			assign den_in  = in_den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign den_in  = den_s[g-1];
			assign quo_in  = quo_s[g-1];
			assign side_in = side_s[g-1];
		end

		// compare against the divisor aligned to this bit
		assign trial = DREMW'(den_in) << J;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= ge ? (rem_in - trial) : rem_in;
			den_s[g]  <= den_in;
			quo_s[g]  <= {quo_in[QW-2:0], ge};
			side_s[g] <= side_in;
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule
`default_nettype wire
